>>> design/wstr_pkg.sv
// ----------------------------------------------------------------------------
// wstr_pkg
// Shared types and codes of the WebSocket text frame receiver.
// ----------------------------------------------------------------------------
package wstr_pkg;

  localparam int ByteW   = 8;
  localparam int StatusW = 3;
  localparam int LenW    = 16;
  localparam int KeyW    = 32;

  localparam logic [StatusW-1:0] ST_DATA  = 3'd0;
  localparam logic [StatusW-1:0] ST_EMPTY = 3'd1;
  localparam logic [StatusW-1:0] ST_CLOSE = 3'd2;
  localparam logic [StatusW-1:0] ST_BADOP = 3'd3;
  localparam logic [StatusW-1:0] ST_LEN64 = 3'd4;

  localparam logic [3:0] OPC_TEXT  = 4'h1;
  localparam logic [3:0] OPC_CLOSE = 4'h8;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  typedef struct packed {
    logic [ByteW-1:0]   payload_byte;
    logic [StatusW-1:0] status;
    logic               frame_last;
  } res_t;

endpackage

>>> design/wstr_stream_if.sv
// ----------------------------------------------------------------------------
// wstr_byte_if / wstr_res_if
// Valid/ready channels for received bytes and for parser results.
// ----------------------------------------------------------------------------
interface wstr_byte_if;
  logic                     valid;
  logic                     ready;
  logic [wstr_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wstr_res_if;
  logic                         valid;
  logic                         ready;
  logic [wstr_pkg::ByteW-1:0]   payload_byte;
  logic [wstr_pkg::StatusW-1:0] status;
  logic                         frame_last;

  modport source (output valid, output payload_byte, output status, output frame_last,
                  input ready);
  modport sink   (input valid, input payload_byte, input status, input frame_last,
                  output ready);
endinterface

>>> design/wstr_in_stage.sv
// ----------------------------------------------------------------------------
// wstr_in_stage
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module wstr_in_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [wstr_pkg::ByteW-1:0] in_byte,
  input  logic                       take,
  output logic                       held_valid,
  output logic [wstr_pkg::ByteW-1:0] held_byte
);

  logic                       vld_r;
  logic                       vld_nxt;
  logic [wstr_pkg::ByteW-1:0] byte_r;

  assign in_ready   = !vld_r || take;
  assign held_valid = vld_r;
  assign held_byte  = byte_r;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

endmodule

>>> design/wstr_parser.sv
// ----------------------------------------------------------------------------
// wstr_parser
// Frame header parser and payload unmasking, one byte per step.
// ----------------------------------------------------------------------------
module wstr_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [wstr_pkg::ByteW-1:0] rx_byte,
  output logic                       res_valid,
  output wstr_pkg::res_t             res
);

  localparam logic [3:0] PH_HDR0 = 4'd0;
  localparam logic [3:0] PH_HDR1 = 4'd1;
  localparam logic [3:0] PH_EXT0 = 4'd2;
  localparam logic [3:0] PH_EXT1 = 4'd3;
  localparam logic [3:0] PH_MASK = 4'd4;
  localparam logic [3:0] PH_DATA = 4'd5;

  logic [3:0]                 phase_r,  phase_nxt;
  logic [wstr_pkg::LenW-1:0]  rem_r,    rem_nxt;
  logic [wstr_pkg::ByteW-1:0] len_hi_r, len_hi_nxt;
  logic [wstr_pkg::KeyW-1:0]  key_r,    key_nxt;
  logic [1:0]                 pos_r,    pos_nxt;
  logic                       masked_r, masked_nxt;
  logic                       halted_r, halted_nxt;

  always_comb begin
    logic [wstr_pkg::LenW-1:0]  len_v;
    logic                       masked_v;
    logic                       len_done;
    logic                       hdr_done;
    logic [wstr_pkg::ByteW-1:0] kb;

    phase_nxt  = phase_r;
    rem_nxt    = rem_r;
    len_hi_nxt = len_hi_r;
    key_nxt    = key_r;
    pos_nxt    = pos_r;
    masked_nxt = masked_r;
    halted_nxt = halted_r;
    res_valid  = 1'b0;
    res        = '0;
    len_v      = rem_r;
    masked_v   = masked_r;
    len_done   = 1'b0;
    hdr_done   = 1'b0;
    kb         = '0;

    if (step && !halted_r) begin
      case (phase_r)
        PH_HDR1: begin
          masked_nxt = rx_byte[7];
          masked_v   = rx_byte[7];
          if (rx_byte[6:0] == wstr_pkg::LEN7_EXT64) begin
            halted_nxt     = 1'b1;
            res_valid      = 1'b1;
            res.status     = wstr_pkg::ST_LEN64;
            res.frame_last = 1'b1;
          end else if (rx_byte[6:0] == wstr_pkg::LEN7_EXT16) begin
            phase_nxt = PH_EXT0;
          end else begin
            len_v    = {{(wstr_pkg::LenW-7){1'b0}}, rx_byte[6:0]};
            rem_nxt  = len_v;
            len_done = 1'b1;
          end
        end
        PH_EXT0: begin
          len_hi_nxt = rx_byte;
          phase_nxt  = PH_EXT1;
        end
        PH_EXT1: begin
          len_v    = {len_hi_r, rx_byte};
          rem_nxt  = len_v;
          len_done = 1'b1;
        end
        PH_MASK: begin
          key_nxt = {key_r[wstr_pkg::KeyW-9:0], rx_byte};
          if (pos_r == 2'd3) begin
            hdr_done = 1'b1;
          end else begin
            pos_nxt = pos_r + 2'd1;
          end
        end
        PH_DATA: begin
          if (masked_r) begin
            case (pos_r)
              2'd0:    kb = key_r[31:24];
              2'd1:    kb = key_r[23:16];
              2'd2:    kb = key_r[15:8];
              default: kb = key_r[7:0];
            endcase
          end
          pos_nxt          = pos_r + 2'd1;
          rem_nxt          = rem_r - 16'd1;
          res_valid        = 1'b1;
          res.payload_byte = rx_byte ^ kb;
          res.status       = wstr_pkg::ST_DATA;
          if (rem_r == 16'd1) begin
            res.frame_last = 1'b1;
            phase_nxt      = PH_HDR0;
          end
        end
        default: begin
          if (rx_byte[3:0] == wstr_pkg::OPC_CLOSE) begin
            halted_nxt     = 1'b1;
            res_valid      = 1'b1;
            res.status     = wstr_pkg::ST_CLOSE;
            res.frame_last = 1'b1;
          end else if (rx_byte[3:0] != wstr_pkg::OPC_TEXT) begin
            halted_nxt     = 1'b1;
            res_valid      = 1'b1;
            res.status     = wstr_pkg::ST_BADOP;
            res.frame_last = 1'b1;
          end else begin
            phase_nxt = PH_HDR1;
          end
        end
      endcase

      if (len_done) begin
        if (masked_v) begin
          pos_nxt   = 2'd0;
          phase_nxt = PH_MASK;
        end else begin
          hdr_done = 1'b1;
        end
      end

      if (hdr_done) begin
        pos_nxt = 2'd0;
        if (len_v == '0) begin
          phase_nxt      = PH_HDR0;
          res_valid      = 1'b1;
          res.status     = wstr_pkg::ST_EMPTY;
          res.frame_last = 1'b1;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      rem_r    <= '0;
      len_hi_r <= '0;
      key_r    <= '0;
      pos_r    <= '0;
      masked_r <= 1'b0;
      halted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      rem_r    <= rem_nxt;
      len_hi_r <= len_hi_nxt;
      key_r    <= key_nxt;
      pos_r    <= pos_nxt;
      masked_r <= masked_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

>>> design/wstr_out_stage.sv
// ----------------------------------------------------------------------------
// wstr_out_stage
// Result register toward the downstream channel.
// ----------------------------------------------------------------------------
module wstr_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  logic           res_valid,
  input  wstr_pkg::res_t res,
  output logic           free,
  output logic           out_valid,
  input  logic           out_ready,
  output wstr_pkg::res_t out_res
);

  logic           vld_r;
  logic           vld_nxt;
  wstr_pkg::res_t res_r;

  assign free      = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_comb begin
    vld_nxt = vld_r;
    if (out_ready) begin
      vld_nxt = 1'b0;
    end
    if (load && res_valid) begin
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      res_r <= res;
    end
  end

endmodule

>>> design/websocket_text_frame_receiver.sv
// ----------------------------------------------------------------------------
// websocket_text_frame_receiver
// Parses back-to-back WebSocket text frames from a byte stream.
// ----------------------------------------------------------------------------
// Takes one received byte per item and can accept an item every cycle. A byte
// is held in an input register, passes one step of the header/unmask logic and
// lands in a result register; header and mask key bytes give no result. The
// input stalls only while a result waits in the result register with out_ready
// low. Each payload byte comes out unmasked with frame_last on the final one;
// an empty text frame gives one status item. Close, other non-text opcodes and
// the 64-bit length form give an error item and the block then drops every
// byte until reset.
module websocket_text_frame_receiver (
  input  logic       clk,
  input  logic       rst_n,
  wstr_byte_if.sink  in_ch,
  wstr_res_if.source out_ch
);

  logic                       take;
  logic                       held_valid;
  logic [wstr_pkg::ByteW-1:0] held_byte;
  logic                       res_valid;
  logic                       out_free;
  wstr_pkg::res_t             res;
  wstr_pkg::res_t             out_res;

  assign take = held_valid && out_free;

  wstr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_byte    (in_ch.rx_byte),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  wstr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (take),
    .rx_byte   (held_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  wstr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take),
    .res_valid (res_valid),
    .res       (res),
    .free      (out_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.payload_byte = out_res.payload_byte;
  assign out_ch.status       = out_res.status;
  assign out_ch.frame_last   = out_res.frame_last;

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the WebSocket text frame receiver.
// Streams back-to-back text frames (plain, masked and 16-bit length forms)
// through the byte channel. The expected unmasked bytes and empty-frame items
// are computed from the accepted bytes and matched in order against the
// result channel. Both sides idle at random. The run closes with one error
// frame, then a few bytes that the halted block must drop.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [3:0] HDR0   = 4'd0;
  localparam logic [3:0] HDR1   = 4'd1;
  localparam logic [3:0] EXT_HI = 4'd2;
  localparam logic [3:0] EXT_LO = 4'd3;
  localparam logic [3:0] KEY    = 4'd4;
  localparam logic [3:0] BODY   = 4'd5;

  logic clk;
  logic rst_n;

  wstr_byte_if byte_ch ();
  wstr_res_if  res_ch ();

  websocket_text_frame_receiver DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (byte_ch),
    .out_ch (res_ch)
  );

  logic [wstr_pkg::ByteW-1:0] pending_bytes[$];
  wstr_pkg::res_t             expected_results[$];

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned fill_count;
  int unsigned n_errors;
  bit          byte_taken;

  // parser state as the frame format defines it
  logic [3:0]                 ph;
  logic [wstr_pkg::LenW-1:0]  remaining;
  logic [wstr_pkg::ByteW-1:0] len_hi;
  logic [wstr_pkg::KeyW-1:0]  key;
  logic [1:0]                 key_idx;
  bit                         masked;
  bit                         stopped;

  always #1 clk = ~clk;

  task automatic push_byte(input logic [wstr_pkg::ByteW-1:0] b);
    pending_bytes = {pending_bytes, b};
    fill_count++;
  endtask

  task automatic queue_result(input wstr_pkg::res_t r);
    expected_results = {expected_results, r};
  endtask

  task automatic put_header(input int unsigned len, input bit m, input bit ext,
                            input logic [wstr_pkg::KeyW-1:0] k);
    logic [3:0]                hi;
    logic [wstr_pkg::LenW-1:0] l16;
    hi  = 4'($urandom);
    l16 = 16'(len);
    push_byte({hi, wstr_pkg::OPC_TEXT});
    if (ext || len >= 126) begin
      push_byte({m, wstr_pkg::LEN7_EXT16});
      push_byte(l16[15:8]);
      push_byte(l16[7:0]);
    end else begin
      push_byte({m, l16[6:0]});
    end
    if (m) begin
      push_byte(k[31:24]);
      push_byte(k[23:16]);
      push_byte(k[15:8]);
      push_byte(k[7:0]);
    end
  endtask

  task automatic put_random_frames(input int unsigned n_bytes);
    int unsigned r;
    int unsigned len;
    bit          ext;
    fill_count = 0;
    while (fill_count < n_bytes) begin
      r   = $urandom_range(99);
      ext = 1'b0;
      if (r < 8) len = 0;
      else if (r < 70) len = $urandom_range(12, 1);
      else if (r < 85) len = $urandom_range(125, 13);
      else begin
        len = $urandom_range(200);
        ext = 1'b1;
      end
      put_header(len, 1'($urandom_range(1)), ext, $urandom);
      repeat (len) push_byte(8'($urandom));
    end
  endtask

  task automatic start_body(output bit have, output wstr_pkg::res_t r);
    key_idx = 2'd0;
    have    = 1'b0;
    if (remaining == '0) begin
      ph           = HDR0;
      r            = '0;
      r.status     = wstr_pkg::ST_EMPTY;
      r.frame_last = 1'b1;
      have         = 1'b1;
    end else begin
      ph = BODY;
    end
  endtask

  task automatic length_known(output bit have, output wstr_pkg::res_t r);
    have = 1'b0;
    if (masked) begin
      key_idx = 2'd0;
      ph      = KEY;
    end else begin
      start_body(have, r);
    end
  endtask

  task automatic predict_byte(input logic [wstr_pkg::ByteW-1:0] b);
    wstr_pkg::res_t             r;
    bit                         have;
    logic [wstr_pkg::ByteW-1:0] kb;
    r    = '0;
    have = 1'b0;
    if (!stopped) begin
      case (ph)
        HDR1: begin
          masked = b[7];
          if (b[6:0] == wstr_pkg::LEN7_EXT64) begin
            stopped      = 1'b1;
            r.status     = wstr_pkg::ST_LEN64;
            r.frame_last = 1'b1;
            have         = 1'b1;
          end else if (b[6:0] == wstr_pkg::LEN7_EXT16) begin
            ph = EXT_HI;
          end else begin
            remaining = {9'd0, b[6:0]};
            length_known(have, r);
          end
        end
        EXT_HI: begin
          len_hi = b;
          ph     = EXT_LO;
        end
        EXT_LO: begin
          remaining = {len_hi, b};
          length_known(have, r);
        end
        KEY: begin
          key = {key[23:0], b};
          if (key_idx == 2'd3) start_body(have, r);
          else key_idx = key_idx + 2'd1;
        end
        BODY: begin
          kb = '0;
          if (masked) kb = key[31 - 8 * key_idx -: 8];
          key_idx        = key_idx + 2'd1;
          remaining      = remaining - 1'b1;
          r.payload_byte = b ^ kb;
          r.status       = wstr_pkg::ST_DATA;
          r.frame_last   = (remaining == '0);
          have           = 1'b1;
          if (remaining == '0) ph = HDR0;
        end
        default: begin
          if (b[3:0] == wstr_pkg::OPC_CLOSE) begin
            stopped      = 1'b1;
            r.status     = wstr_pkg::ST_CLOSE;
            r.frame_last = 1'b1;
            have         = 1'b1;
          end else if (b[3:0] != wstr_pkg::OPC_TEXT) begin
            stopped      = 1'b1;
            r.status     = wstr_pkg::ST_BADOP;
            r.frame_last = 1'b1;
            have         = 1'b1;
          end else begin
            ph = HDR1;
          end
        end
      endcase
    end
    if (have) queue_result(r);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || byte_ch.valid || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // byte channel: accept at rising edge, drive at falling edge
  always @(posedge clk) begin
    if (rst_n && byte_ch.valid && byte_ch.ready) begin
      predict_byte(byte_ch.rx_byte);
      byte_taken <= 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!byte_ch.valid || byte_taken) begin
        if (pending_bytes.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          byte_ch.valid   <= 1'b1;
          byte_ch.rx_byte <= pending_bytes.pop_front();
        end else begin
          byte_ch.valid   <= 1'b0;
          byte_ch.rx_byte <= 8'($urandom);
        end
      end
      byte_taken <= 1'b0;
    end
  end

  // result channel
  always @(negedge clk) begin
    if (rst_n) res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    wstr_pkg::res_t exp_r;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected item byte=%02h status=%0d last=%0b", $time,
                 res_ch.payload_byte, res_ch.status, res_ch.frame_last);
      end else begin
        exp_r = expected_results.pop_front();
        if (res_ch.payload_byte !== exp_r.payload_byte || res_ch.status !== exp_r.status ||
            res_ch.frame_last !== exp_r.frame_last) begin
          n_errors++;
          $display({"%0t: mismatch expected byte=%02h status=%0d last=%0b, ",
                    "got byte=%02h status=%0d last=%0b"},
                   $time, exp_r.payload_byte, exp_r.status, exp_r.frame_last,
                   res_ch.payload_byte, res_ch.status, res_ch.frame_last);
        end
      end
    end
  end

  initial begin
    #600000;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    logic [3:0] hi;
    logic [3:0] opc;
    clk             = 1'b0;
    rst_n           = 1'b0;
    byte_ch.valid   = 1'b0;
    byte_ch.rx_byte = '0;
    res_ch.ready    = 1'b0;
    byte_taken      = 1'b0;
    n_errors        = 0;
    ph              = HDR0;
    remaining       = '0;
    len_hi          = '0;
    key             = '0;
    key_idx         = 2'd0;
    masked          = 1'b0;
    stopped         = 1'b0;
    src_idle_pct    = 18;
    sink_idle_pct   = 50;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty frames in the plain, masked and 16-bit length forms, key and payload extremes
    put_header(0, 1'b0, 1'b0, '0);
    put_header(0, 1'b1, 1'b0, 32'hFFFF_FFFF);
    put_header(0, 1'b0, 1'b1, '0);
    put_header(3, 1'b1, 1'b0, 32'hFF00_A55A);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h5A);
    put_header(2, 1'b0, 1'b0, '0);
    push_byte(8'hFF);
    push_byte(8'h00);
    put_random_frames(500);
    wait_idle();

    src_idle_pct  = 50;
    sink_idle_pct = 18;
    put_random_frames(500);
    wait_idle();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    put_header(16'h0105, 1'b1, 1'b1, $urandom);
    repeat (16'h0105) push_byte(8'($urandom));
    put_random_frames(250);
    wait_idle();

    // one error frame halts the block for good, so it comes last
    hi = 4'($urandom);
    case ($urandom_range(2))
      0: push_byte({hi, wstr_pkg::OPC_CLOSE});
      1: begin
        do opc = 4'($urandom);
        while (opc == wstr_pkg::OPC_TEXT || opc == wstr_pkg::OPC_CLOSE);
        push_byte({hi, opc});
      end
      default: begin
        push_byte({hi, wstr_pkg::OPC_TEXT});
        push_byte({1'($urandom_range(1)), wstr_pkg::LEN7_EXT64});
      end
    endcase
    repeat (8) push_byte(8'($urandom));
    wait_idle();
    repeat (8) @(negedge clk);

    if (n_errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
